// ===== sv/greedy_box_suppression_assert.svh =====
// Assertion macros used by the greedy box suppression checker.
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
`timescale 1ns / 1ps

package gbs_pkg;

    // Kept-list depth and the widths that follow from it.
    localparam int MAX_KEPT = 64;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int SPAN_W  = 16;
    localparam int AREA_W  = 32;
    localparam int POS_W   = 10;
    localparam int THR_W   = 9;
    localparam int THR_FRAC_BITS = 8;

    localparam logic [THR_W-1:0] THR_RESET = 9'd128;

    // Input word: one box in signed Q12.4 pixels.
    typedef struct packed {
        logic                      frame_start;
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic signed [COORD_W-1:0] box_width;
        logic signed [COORD_W-1:0] box_height;
    } gbs_req_t;

    // Result word.
    typedef struct packed {
        logic             keep;
        logic [POS_W-1:0] box_position;
        logic [CNT_W-1:0] kept_total;
        logic             list_overflow;
    } gbs_rsp_t;

    // One box in edge form, as stored in the kept list.
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [EDGE_W-1:0]  right;
        logic signed [EDGE_W-1:0]  bottom;
        logic [AREA_W-1:0]         area;
    } gbs_entry_t;

    // Status from the overlap unit back to the sequencer.
    typedef struct packed {
        logic              busy;
        logic              inter_valid;
        logic [AREA_W-1:0] inter;
        logic              hit;
    } gbs_stat_t;

endpackage

// ===== sv/gbs_iou_unit.sv =====
// Pipelined overlap test of one box against one kept box per cycle.
`timescale 1ns / 1ps

module gbs_iou_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          flush,
    input  logic                          valid,
    input  gbs_pkg::gbs_entry_t           box,
    input  gbs_pkg::gbs_entry_t           entry,
    input  logic [gbs_pkg::THR_W-1:0]     thr,
    output gbs_pkg::gbs_stat_t            stat
);

    localparam int UNI_W  = gbs_pkg::AREA_W + 1;
    localparam int PROD_W = UNI_W + gbs_pkg::THR_W;
    localparam int DIFF_W = gbs_pkg::EDGE_W + 1;

    logic signed [gbs_pkg::EDGE_W-1:0] bl, bt, kl, kt;
    logic signed [gbs_pkg::EDGE_W-1:0] x0, y0, x1, y1;
    logic signed [DIFF_W-1:0]          dx, dy;
    logic [gbs_pkg::SPAN_W-1:0]        sx, sy;

    logic                         v1_reg, v2_reg, v3_reg, v4_reg;
    logic [gbs_pkg::SPAN_W-1:0]   sx1_reg, sy1_reg;
    logic [gbs_pkg::AREA_W-1:0]   karea1_reg, karea2_reg;
    logic [gbs_pkg::AREA_W-1:0]   inter2_reg, inter3_reg, inter4_reg;
    logic [UNI_W-1:0]             uni3_reg;
    logic [PROD_W-1:0]            prod4_reg;
    logic                         nz4_reg;

    // Intersection rectangle; its spans are clipped at zero.
    always_comb
    begin
        bl = {box.left[gbs_pkg::COORD_W-1], box.left};
        bt = {box.top[gbs_pkg::COORD_W-1], box.top};
        kl = {entry.left[gbs_pkg::COORD_W-1], entry.left};
        kt = {entry.top[gbs_pkg::COORD_W-1], entry.top};
        x0 = (bl > kl) ? bl : kl;
        y0 = (bt > kt) ? bt : kt;
        x1 = (box.right < entry.right) ? box.right : entry.right;
        y1 = (box.bottom < entry.bottom) ? box.bottom : entry.bottom;
        dx = {x1[gbs_pkg::EDGE_W-1], x1} - {x0[gbs_pkg::EDGE_W-1], x0};
        dy = {y1[gbs_pkg::EDGE_W-1], y1} - {y0[gbs_pkg::EDGE_W-1], y0};
        sx = (dx > 0) ? dx[gbs_pkg::SPAN_W-1:0] : '0;
        sy = (dy > 0) ? dy[gbs_pkg::SPAN_W-1:0] : '0;
    end

    // Stage valids; a flush drops everything in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (flush)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Datapath: spans, intersection product, union, threshold product.
    always_ff @(posedge clk)
    begin
        sx1_reg    <= sx;
        sy1_reg    <= sy;
        karea1_reg <= entry.area;
        inter2_reg <= gbs_pkg::AREA_W'(sx1_reg) * gbs_pkg::AREA_W'(sy1_reg);
        karea2_reg <= karea1_reg;
        inter3_reg <= inter2_reg;
        uni3_reg   <= {1'b0, box.area} + {1'b0, karea2_reg} - {1'b0, inter2_reg};
        inter4_reg <= inter3_reg;
        prod4_reg  <= PROD_W'(thr) * PROD_W'(uni3_reg);
        nz4_reg    <= (uni3_reg != '0);
    end

    // Suppression when inter * 256 exceeds threshold * union.
    always_comb
    begin
        stat.busy        = v1_reg | v2_reg | v3_reg | v4_reg;
        stat.inter_valid = v2_reg;
        stat.inter       = inter2_reg;
        stat.hit         = v4_reg && nz4_reg &&
                           ({{(PROD_W - gbs_pkg::AREA_W - gbs_pkg::THR_FRAC_BITS){1'b0}},
                             inter4_reg, {gbs_pkg::THR_FRAC_BITS{1'b0}}} > prod4_reg);
    end

endmodule

// ===== sv/greedy_box_suppression.sv =====
// Greedy box suppression top level: sequencer, kept-list memory and ports.
// Boxes arrive in descending score order, one word each, and each result word
// reports whether the box survives greedy suppression against the boxes kept
// so far in the frame (overlap test inter * 256 > overlap_threshold * union).
// Each box is first run against itself in the overlap pipeline to form its own
// area. The stored boxes are then read from the kept-list memory, one per cycle,
// and streamed through the pipeline until every stored box has been tested and
// the pipeline has drained; the result is then posted and the block returns to
// idle to take the next box. A suppressing hit on a stored box ends the scan
// early and flushes the pipeline. req_ready is high only between boxes. A
// finished result sits in the output register, so the next box is accepted
// while it waits; the next result is posted only once that register is free.
// The threshold register may be written at any time the block is idle and
// resets to 0.5.
`timescale 1ns / 1ps

module greedy_box_suppression (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  gbs_pkg::gbs_req_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output gbs_pkg::gbs_rsp_t         rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gbs_pkg::THR_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA_ISSUE,
        S_AREA_WAIT,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    gbs_pkg::gbs_entry_t             box_reg, box_next;
    logic [gbs_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [gbs_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [gbs_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [gbs_pkg::THR_W-1:0]       thr_reg, thr_next;
    logic                            keep_reg, keep_next;
    logic                            rd_valid_reg, rd_valid_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    gbs_pkg::gbs_rsp_t               rsp_reg, rsp_next;

    gbs_pkg::gbs_entry_t             mem [gbs_pkg::MAX_KEPT];
    gbs_pkg::gbs_entry_t             mem_q_reg;
    logic                            append;
    logic                            list_full;
    logic                            retire;

    gbs_pkg::gbs_entry_t             unit_entry;
    logic                            unit_valid;
    logic                            unit_flush;
    gbs_pkg::gbs_stat_t              stat;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign list_full = (count_reg >= gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT));
    assign retire    = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);
    assign append    = retire && keep_reg && !list_full;

    // The box is first run against itself to get its own area.
    assign unit_valid = (state_reg == S_AREA_ISSUE) || rd_valid_reg;
    assign unit_entry = (state_reg == S_AREA_ISSUE) ? box_reg : mem_q_reg;
    assign unit_flush = ((state_reg == S_AREA_WAIT) && stat.inter_valid) ||
                        ((state_reg == S_SCAN) && stat.hit);

    gbs_iou_unit u_iou (
        .clk   (clk),
        .rst_n (rst_n),
        .flush (unit_flush),
        .valid (unit_valid),
        .box   (box_reg),
        .entry (unit_entry),
        .thr   (thr_reg),
        .stat  (stat)
    );

    // Kept-list memory: one write port for appends, one registered read port.
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            mem[count_reg[gbs_pkg::ADDR_W-1:0]] <= box_reg;
        end
        mem_q_reg <= mem[idx_reg[gbs_pkg::ADDR_W-1:0]];
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        box_next       = box_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        thr_next       = thr_reg;
        keep_next      = keep_reg;
        rd_valid_next  = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            thr_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    box_next.left   = req.box_left;
                    box_next.top    = req.box_top;
                    box_next.right  = {req.box_left[gbs_pkg::COORD_W-1], req.box_left} +
                                      {req.box_width[gbs_pkg::COORD_W-1], req.box_width};
                    box_next.bottom = {req.box_top[gbs_pkg::COORD_W-1], req.box_top} +
                                      {req.box_height[gbs_pkg::COORD_W-1], req.box_height};
                    keep_next       = 1'b1;
                    if (req.frame_start)
                    begin
                        count_next = '0;
                        pos_next   = '0;
                    end
                    state_next = S_AREA_ISSUE;
                end
            end

            S_AREA_ISSUE:
            begin
                state_next = S_AREA_WAIT;
            end

            S_AREA_WAIT:
            begin
                if (stat.inter_valid)
                begin
                    box_next.area = stat.inter;
                    idx_next      = '0;
                    state_next    = S_SCAN;
                end
            end

            // Stream stored boxes through the overlap unit until a hit or the end.
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    keep_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (idx_reg < count_reg)
                begin
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                end
                else if (!rd_valid_reg && !stat.busy)
                begin
                    keep_next  = 1'b1;
                    state_next = S_DONE;
                end
            end

            // Post the result word once the output register is free.
            S_DONE:
            begin
                if (retire)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.keep          = keep_reg;
                    rsp_next.box_position  = pos_reg;
                    rsp_next.list_overflow = keep_reg && list_full;
                    rsp_next.kept_total    = append ? (count_reg + 1'b1) : count_reg;
                    count_next             = append ? (count_reg + 1'b1) : count_reg;
                    pos_next               = pos_reg + 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            thr_reg       <= gbs_pkg::THR_RESET;
            keep_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            box_reg       <= box_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            thr_reg       <= thr_next;
            keep_reg      <= keep_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

// ===== sv/gbs_checker.sv =====
// Port-level checker for the greedy box suppression block, with its bind.
`timescale 1ns / 1ps
`include "greedy_box_suppression_assert.svh"

module gbs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input gbs_pkg::gbs_rsp_t         rsp
);

    // A waiting result word holds until it is taken.
    `GBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result word changed while stalled")

    // The block works on one box at a time.
    `GBS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted a box while busy")

    // Overflow is reported only for a kept box.
    `GBS_ASSERT_NOW(a_overflow_kept, rsp_valid && rsp.list_overflow, rsp.keep, "overflow on a suppressed box")

    // Overflow means the list is exactly full.
    `GBS_ASSERT_NOW(a_overflow_full, rsp_valid && rsp.list_overflow, rsp.kept_total == gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT), "overflow with list not full")

    // The stored count never passes the list depth.
    `GBS_ASSERT_NOW(a_total_bound, rsp_valid, rsp.kept_total <= gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT), "kept total beyond list depth")

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
